>>> hdl/dvrt_pkg.sv
package dvrt_pkg;

    localparam int TABLE_DEPTH = 32;
    localparam int MAX_RESULTS = 32;

    localparam logic [2:0] STATUS_ADDED      = 3'd0;
    localparam logic [2:0] STATUS_SET        = 3'd1;
    localparam logic [2:0] STATUS_REPLACED   = 3'd2;
    localparam logic [2:0] STATUS_UNCHANGED  = 3'd3;
    localparam logic [2:0] STATUS_FULL       = 3'd4;
    localparam logic [2:0] STATUS_ADVERTISED = 3'd5;

    localparam logic FUNC_UPDATE    = 1'b0;
    localparam logic FUNC_ADVERTISE = 1'b1;

    typedef struct packed {
        logic        func;
        logic [31:0] neighbor_addr;
        logic [31:0] dest_addr;
        logic [15:0] adv_metric;
    } cmd_t;

    typedef struct packed {
        logic [2:0]  status;
        logic [31:0] route_dest;
        logic [15:0] route_metric;
        logic        last_entry;
    } res_t;

    typedef struct packed {
        logic [31:0] dest;
        logic [15:0] metric;
        logic [31:0] gateway;
    } entry_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_FLUSH
    } state_t;

endpackage

>>> hdl/dvrt_ram.sv
module dvrt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

>>> hdl/distance_vector_route_table.sv
// Route table: one entry read per cycle from a registered-read RAM, at most one write per update.
// Update: the result strobe comes early on a destination hit, else once the whole table is
// scanned; busy until then, so a new item is taken only after the last one is done.
// Advertise: at most one result per cycle during the scan, the last one held back and sent
// from the flush state, none if no route qualifies; the scan stops at MAX_RESULTS routes.
// Reset: valid bits cleared at once, table enabled, no clearing pass; results cannot stall.
module distance_vector_route_table #(
    parameter int TABLE_DEPTH = dvrt_pkg::TABLE_DEPTH
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           start,
    input  dvrt_pkg::cmd_t cmd,
    output logic           busy,
    output logic           result_valid,
    output dvrt_pkg::res_t result,
    input  logic           cfg_we,
    input  logic           cfg_wdata
);

    localparam int IDX_W = $clog2(TABLE_DEPTH);
    localparam int CNT_W = $clog2(dvrt_pkg::MAX_RESULTS + 1);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_MAX  = CNT_W'(dvrt_pkg::MAX_RESULTS);

    dvrt_pkg::state_t state_reg, state_next;
    logic                   enabled_reg;
    logic                   func_reg, func_next;
    logic [31:0]            nbr_reg, nbr_next;
    logic [31:0]            dst_reg, dst_next;
    logic [15:0]            metric_reg, metric_next;
    logic [IDX_W-1:0]       addr_reg, addr_next;
    logic                   issue_reg, issue_next;
    logic                   rd_pend_reg, rd_pend_next;
    logic [IDX_W-1:0]       rd_idx_reg, rd_idx_next;
    logic                   free_found_reg, free_found_next;
    logic [IDX_W-1:0]       free_idx_reg, free_idx_next;
    logic                   pend_valid_reg, pend_valid_next;
    dvrt_pkg::res_t         pend_reg, pend_next;
    logic [CNT_W-1:0]       total_reg, total_next;
    logic [TABLE_DEPTH-1:0] valid_reg, valid_next;
    logic                   out_valid_reg, out_valid_next;
    dvrt_pkg::res_t         out_reg, out_next;

    logic                   mem_we;
    logic [IDX_W-1:0]       mem_waddr;
    dvrt_pkg::entry_t       mem_wdata;
    dvrt_pkg::entry_t       mem_rdata;

    logic                   accept;
    logic                   cur_valid;
    logic                   last_proc;
    logic                   eff_free;
    logic [IDX_W-1:0]       eff_free_idx;

    dvrt_ram #(
        .WIDTH ($bits(dvrt_pkg::entry_t)),
        .DEPTH (TABLE_DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (addr_reg),
        .rdata (mem_rdata)
    );

    assign busy         = (state_reg != dvrt_pkg::ST_IDLE);
    assign accept       = start && !busy;
    assign result_valid = out_valid_reg;
    assign result       = out_reg;

    assign cur_valid    = valid_reg[rd_idx_reg];
    assign last_proc    = (rd_idx_reg == LAST_IDX);
    assign eff_free     = free_found_reg || !cur_valid;
    assign eff_free_idx = free_found_reg ? free_idx_reg : rd_idx_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= dvrt_pkg::ST_IDLE;
            enabled_reg    <= 1'b1;
            issue_reg      <= 1'b0;
            rd_pend_reg    <= 1'b0;
            free_found_reg <= 1'b0;
            pend_valid_reg <= 1'b0;
            total_reg      <= '0;
            valid_reg      <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            if (cfg_we)
            begin
                enabled_reg <= cfg_wdata;
            end
            issue_reg      <= issue_next;
            rd_pend_reg    <= rd_pend_next;
            free_found_reg <= free_found_next;
            pend_valid_reg <= pend_valid_next;
            total_reg      <= total_next;
            valid_reg      <= valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        func_reg     <= func_next;
        nbr_reg      <= nbr_next;
        dst_reg      <= dst_next;
        metric_reg   <= metric_next;
        addr_reg     <= addr_next;
        rd_idx_reg   <= rd_idx_next;
        free_idx_reg <= free_idx_next;
        pend_reg     <= pend_next;
        out_reg      <= out_next;
    end

    always_comb
    begin
        state_next      = state_reg;
        func_next       = func_reg;
        nbr_next        = nbr_reg;
        dst_next        = dst_reg;
        metric_next     = metric_reg;
        addr_next       = addr_reg;
        issue_next      = issue_reg;
        rd_pend_next    = 1'b0;
        rd_idx_next     = addr_reg;
        free_found_next = free_found_reg;
        free_idx_next   = free_idx_reg;
        pend_valid_next = pend_valid_reg;
        pend_next       = pend_reg;
        total_next      = total_reg;
        valid_next      = valid_reg;
        out_valid_next  = 1'b0;
        out_next        = out_reg;
        mem_we          = 1'b0;
        mem_waddr       = rd_idx_reg;
        mem_wdata       = '{dest: dst_reg, metric: metric_reg, gateway: nbr_reg};

        case (state_reg)
            dvrt_pkg::ST_IDLE:
            begin
                if (accept && enabled_reg)
                begin
                    state_next      = dvrt_pkg::ST_SCAN;
                    func_next       = cmd.func;
                    nbr_next        = cmd.neighbor_addr;
                    dst_next        = cmd.dest_addr;
                    metric_next     = (cmd.adv_metric == 16'hFFFF) ? 16'hFFFF
                                                                  : cmd.adv_metric + 16'd1;
                    addr_next       = '0;
                    issue_next      = 1'b1;
                    free_found_next = 1'b0;
                    pend_valid_next = 1'b0;
                    total_next      = '0;
                end
            end

            dvrt_pkg::ST_SCAN:
            begin
                if (issue_reg)
                begin
                    rd_pend_next = 1'b1;
                    issue_next   = (addr_reg != LAST_IDX);
                    addr_next    = (addr_reg != LAST_IDX) ? addr_reg + IDX_W'(1) : addr_reg;
                end

                if (rd_pend_reg)
                begin
                    if (func_reg == dvrt_pkg::FUNC_UPDATE)
                    begin
                        if (cur_valid && (mem_rdata.dest == dst_reg))
                        begin
                            out_valid_next      = 1'b1;
                            out_next.route_dest = dst_reg;
                            out_next.last_entry = 1'b1;
                            state_next          = dvrt_pkg::ST_IDLE;
                            rd_pend_next        = 1'b0;
                            issue_next          = 1'b0;
                            if (mem_rdata.gateway == nbr_reg)
                            begin
                                mem_we                = 1'b1;
                                out_next.route_metric = metric_reg;
                                out_next.status       = (mem_rdata.metric != metric_reg)
                                                      ? dvrt_pkg::STATUS_SET
                                                      : dvrt_pkg::STATUS_UNCHANGED;
                            end
                            else if (metric_reg < mem_rdata.metric)
                            begin
                                mem_we                = 1'b1;
                                out_next.route_metric = metric_reg;
                                out_next.status       = dvrt_pkg::STATUS_REPLACED;
                            end
                            else
                            begin
                                out_next.route_metric = mem_rdata.metric;
                                out_next.status       = dvrt_pkg::STATUS_UNCHANGED;
                            end
                        end
                        else
                        begin
                            if (!free_found_reg && !cur_valid)
                            begin
                                free_found_next = 1'b1;
                                free_idx_next   = rd_idx_reg;
                            end
                            if (last_proc)
                            begin
                                out_valid_next        = 1'b1;
                                out_next.route_dest   = dst_reg;
                                out_next.route_metric = metric_reg;
                                out_next.last_entry   = 1'b1;
                                state_next            = dvrt_pkg::ST_IDLE;
                                if (eff_free)
                                begin
                                    mem_we                 = 1'b1;
                                    mem_waddr              = eff_free_idx;
                                    valid_next[eff_free_idx] = 1'b1;
                                    out_next.status        = dvrt_pkg::STATUS_ADDED;
                                end
                                else
                                begin
                                    out_next.status = dvrt_pkg::STATUS_FULL;
                                end
                            end
                        end
                    end
                    else
                    begin
                        if (cur_valid && (mem_rdata.gateway != nbr_reg))
                        begin
                            // hold the newest route back until it is known not to be the last
                            if (pend_valid_reg)
                            begin
                                out_valid_next      = 1'b1;
                                out_next            = pend_reg;
                                out_next.last_entry = 1'b0;
                            end
                            pend_valid_next = 1'b1;
                            pend_next       = '{status: dvrt_pkg::STATUS_ADVERTISED,
                                                route_dest: mem_rdata.dest,
                                                route_metric: mem_rdata.metric,
                                                last_entry: 1'b1};
                            total_next      = total_reg + CNT_W'(1);
                        end
                        if ((total_next == CNT_MAX) || last_proc)
                        begin
                            rd_pend_next = 1'b0;
                            issue_next   = 1'b0;
                            state_next   = pend_valid_next ? dvrt_pkg::ST_FLUSH
                                                           : dvrt_pkg::ST_IDLE;
                        end
                    end
                end
            end

            dvrt_pkg::ST_FLUSH:
            begin
                out_valid_next      = 1'b1;
                out_next            = pend_reg;
                out_next.last_entry = 1'b1;
                pend_valid_next     = 1'b0;
                state_next          = dvrt_pkg::ST_IDLE;
            end

            default:
            begin
                state_next = dvrt_pkg::ST_IDLE;
            end
        endcase
    end

    a_result_from_work: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> $past(state_reg) != dvrt_pkg::ST_IDLE)
        else $error("result transfer without an item in progress");

    a_write_on_update: assert property (@(posedge clk) disable iff (!rst_n)
        mem_we |-> (state_reg == dvrt_pkg::ST_SCAN) && (func_reg == dvrt_pkg::FUNC_UPDATE))
        else $error("table write outside an update");

    a_update_single: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && (result.status != dvrt_pkg::STATUS_ADVERTISED) |-> result.last_entry)
        else $error("update result not marked last");

    a_gap_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.last_entry |=> !result_valid)
        else $error("result follows the last one of an item");

    a_count_cap: assert property (@(posedge clk) disable iff (!rst_n)
        total_reg <= CNT_MAX)
        else $error("advertise count beyond cap");

endmodule
